/* sv/iate_pkg.sv */
// shared constants and types for the indexed array table engine
package iate_pkg;

  localparam int DEF_TABLE_DEPTH = 64;
  localparam int DEF_WORD_WIDTH  = 32;

  localparam int OPCODE_W   = 2;
  localparam int VALUE_W    = 32;
  localparam int INDEX_W    = 7;
  localparam int STATUS_W   = 2;
  localparam int POS_OUT_W  = 6;
  localparam int COUNT_W    = 7;
  localparam int CAP_W      = 7;
  localparam int EXT_W      = 64;

  // match bits examined per cycle by the linear scan
  localparam int SCAN_W  = 16;
  localparam int SCAN_LW = 4;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_BSRCH  = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_LSRCH  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISS   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADIDX = 2'd3;

  // broadcast to every cell
  typedef struct packed {
    logic ins;
    logic del;
    logic cmp;
  } cell_cmd_t;

  typedef struct packed {
    logic start;
    logic binary;
  } seek_req_t;

  typedef struct packed {
    logic                 done;
    logic                 hit;
    logic [POS_OUT_W-1:0] pos;
  } seek_rsp_t;

endpackage

/* sv/indexed_array_table_engine.sv */
// top level: row of table cells, count and capacity registers, search sequencer
//
// A request is taken when start is high and busy is low; its single result word
// appears on the out_ ports for one cycle with out_strobe and cannot be held off.
// Insert and delete shift the cells from the index upward at once, so busy stays
// low and a new request may follow in the next cycle; the result shows the cycle
// after. A search latches a compare flag in every cell in its first cycle, then
// raises busy while the sequencer works on those flags: binary search takes one
// probe per cycle (at most clog2(count+1) probes, plus a closing step on a miss),
// linear search examines 16 positions per cycle. capacity_limit is written through
// cfg_wr_en/cfg_wr_data and should be changed only while the block is idle.
module indexed_array_table_engine import iate_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int WORD_WIDTH  = DEF_WORD_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [OPCODE_W-1:0]  in_opcode,
  input  logic [VALUE_W-1:0]   in_item_value,
  input  logic [INDEX_W-1:0]   in_item_index,
  output logic                 out_strobe,
  output logic [STATUS_W-1:0]  out_status,
  output logic [POS_OUT_W-1:0] out_found_position,
  output logic [COUNT_W-1:0]   out_entries_after,
  input  logic                 cfg_wr_en,
  input  logic [CAP_W-1:0]     cfg_wr_data
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IW    = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SEEK = 1'b1;

  logic                   state_r, state_nxt;
  logic [CNT_W-1:0]       used_r, used_nxt;
  logic [CAP_W-1:0]       cap_r;
  logic                   out_strobe_r, out_strobe_nxt;
  logic [STATUS_W-1:0]    out_status_r, out_status_nxt;
  logic [POS_OUT_W-1:0]   out_pos_r, out_pos_nxt;
  logic [COUNT_W-1:0]     out_cnt_r, out_cnt_nxt;

  logic                   accept;
  logic [EXT_W-1:0]       value_ext;
  logic [WORD_WIDTH-1:0]  key;
  logic [IW-1:0]          idx_ext;
  logic [IW-1:0]          used_ext;
  logic [IW-1:0]          cap_ext;
  logic                   full;
  logic                   is_search;
  cell_cmd_t              cmd;
  seek_req_t              sreq;
  seek_rsp_t              srsp;
  logic [CNT_W+COUNT_W-1:0] cnt_pad;

  logic [WORD_WIDTH-1:0]  cell_word [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] eq_vec;
  logic [TABLE_DEPTH-1:0] lt_vec;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r == S_SEEK);
  assign value_ext = {{(EXT_W - VALUE_W){in_item_value[VALUE_W-1]}}, in_item_value};
  assign key       = value_ext[WORD_WIDTH-1:0];
  assign idx_ext   = IW'(in_item_index);
  assign used_ext  = IW'(used_r);
  assign cap_ext   = IW'(cap_r);
  assign is_search = (in_opcode == OP_BSRCH) || (in_opcode == OP_LSRCH);

  // a zero limit acts as one, a limit above the depth acts as the depth
  assign full = (cap_r == '0) ? (used_r != '0)
                              : ((used_ext >= cap_ext) || (used_r == DEPTH_CNT));

  always_comb begin
    cmd         = '0;
    used_nxt    = used_r;
    out_status_nxt = ST_OK;
    if (accept) begin
      case (in_opcode)
        OP_INSERT: begin
          if (full) begin
            out_status_nxt = ST_FULL;
          end else if (idx_ext > used_ext) begin
            out_status_nxt = ST_BADIDX;
          end else begin
            cmd.ins  = 1'b1;
            used_nxt = used_r + CNT_W'(1);
          end
        end
        OP_DELETE: begin
          if (idx_ext >= used_ext) begin
            out_status_nxt = ST_BADIDX;
          end else begin
            cmd.del  = 1'b1;
            used_nxt = used_r - CNT_W'(1);
          end
        end
        default: begin
          cmd.cmp = 1'b1;
        end
      endcase
    end else if ((state_r == S_SEEK) && srsp.done) begin
      out_status_nxt = srsp.hit ? ST_OK : ST_MISS;
    end
  end

  assign sreq.start  = accept && is_search;
  assign sreq.binary = (in_opcode == OP_BSRCH);
  assign cnt_pad     = {{COUNT_W{1'b0}}, used_nxt};

  always_comb begin
    state_nxt      = state_r;
    out_strobe_nxt = 1'b0;
    out_pos_nxt    = '0;
    out_cnt_nxt    = cnt_pad[COUNT_W-1:0];
    if (state_r == S_IDLE) begin
      if (accept) begin
        if (is_search) begin
          state_nxt = S_SEEK;
        end else begin
          out_strobe_nxt = 1'b1;
        end
      end
    end else if (srsp.done) begin
      state_nxt      = S_IDLE;
      out_strobe_nxt = 1'b1;
      out_pos_nxt    = srsp.pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      used_r       <= '0;
      cap_r        <= CAP_RESET;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      used_r       <= used_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_strobe_nxt) begin
      out_status_r <= out_status_nxt;
      out_pos_r    <= out_pos_nxt;
      out_cnt_r    <= out_cnt_nxt;
    end
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic [WORD_WIDTH-1:0] left_w;
    logic [WORD_WIDTH-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = key;
    end else begin : g_mid_l
      assign left_w = cell_word[g-1];
    end
    if (g == TABLE_DEPTH - 1) begin : g_last
      assign right_w = cell_word[g];
    end else begin : g_mid_r
      assign right_w = cell_word[g+1];
    end
    iate_cell #(
      .WORD_WIDTH (WORD_WIDTH),
      .IDX_W      (IW),
      .POS        (g)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .idx        (idx_ext),
      .key        (key),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (cell_word[g]),
      .eq         (eq_vec[g]),
      .lt         (lt_vec[g])
    );
  end

  iate_seek #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_seek (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (sreq),
    .used   (used_r),
    .eq_vec (eq_vec),
    .lt_vec (lt_vec),
    .rsp    (srsp)
  );

  assign out_strobe         = out_strobe_r;
  assign out_status         = out_status_r;
  assign out_found_position = out_pos_r;
  assign out_entries_after  = out_cnt_r;

endmodule

/* sv/iate_cell.sv */
// one table cell: holds a word, shifts with its neighbors, compares against the key
module iate_cell import iate_pkg::*; #(
  parameter int WORD_WIDTH = DEF_WORD_WIDTH,
  parameter int IDX_W      = INDEX_W,
  parameter int POS        = 0
) (
  input  logic                  clk,
  input  cell_cmd_t             cmd,
  input  logic [IDX_W-1:0]      idx,
  input  logic [WORD_WIDTH-1:0] key,
  input  logic [WORD_WIDTH-1:0] left_word,
  input  logic [WORD_WIDTH-1:0] right_word,
  output logic [WORD_WIDTH-1:0] word,
  output logic                  eq,
  output logic                  lt
);

  localparam logic [IDX_W-1:0] MY_POS = IDX_W'(POS);

  logic [WORD_WIDTH-1:0] word_r;
  logic [WORD_WIDTH-1:0] word_nxt;
  logic                  eq_r;
  logic                  lt_r;

  always_comb begin
    word_nxt = word_r;
    if (cmd.ins) begin
      if (MY_POS == idx) begin
        word_nxt = key;
      end else if (MY_POS > idx) begin
        word_nxt = left_word;
      end
    end else if (cmd.del && (MY_POS >= idx)) begin
      word_nxt = right_word;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    if (cmd.cmp) begin
      eq_r <= (word_r == key);
      lt_r <= ($signed(word_r) < $signed(key));
    end
  end

  assign word = word_r;
  assign eq   = eq_r;
  assign lt   = lt_r;

endmodule

/* sv/iate_seek.sv */
// search sequencer over the cells' registered match and less-than flags
module iate_seek import iate_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  seek_req_t                            req,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]     used,
  input  logic [TABLE_DEPTH-1:0]               eq_vec,
  input  logic [TABLE_DEPTH-1:0]               lt_vec,
  output seek_rsp_t                            rsp
);

  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int POS_W   = $clog2(TABLE_DEPTH);
  localparam int N_CHUNK = (TABLE_DEPTH + SCAN_W - 1) / SCAN_W;
  localparam int PAD_W   = N_CHUNK * SCAN_W;
  localparam int CH_W    = (N_CHUNK > 1) ? $clog2(N_CHUNK) : 1;
  localparam logic [CH_W-1:0] LAST_CHUNK = CH_W'(N_CHUNK - 1);

  logic             running_r, running_nxt;
  logic             binary_r, binary_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0] hi_r, hi_nxt;
  logic [CH_W-1:0]  chunk_r, chunk_nxt;

  logic [PAD_W-1:0]          hit_pad;
  logic [SCAN_W-1:0]         chunk_bits;
  logic                      chunk_any;
  logic [SCAN_LW-1:0]        chunk_lpos;
  logic [CNT_W:0]            mid_sum;
  logic [CNT_W-1:0]          mid;
  logic [POS_W-1:0]          mid_i;
  logic [CNT_W+POS_OUT_W-1:0] mid_pad;
  logic [CH_W+SCAN_LW+POS_OUT_W-1:0] lin_pad;

  // only used positions may match
  for (genvar g = 0; g < PAD_W; g++) begin : g_hit
    if (g < TABLE_DEPTH) begin : g_real
      assign hit_pad[g] = eq_vec[g] && (CNT_W'(g) < used);
    end else begin : g_pad
      assign hit_pad[g] = 1'b0;
    end
  end

  assign chunk_bits = hit_pad[chunk_r*SCAN_W +: SCAN_W];

  always_comb begin
    chunk_any  = 1'b0;
    chunk_lpos = '0;
    for (int k = SCAN_W - 1; k >= 0; k--) begin
      if (chunk_bits[k]) begin
        chunk_any  = 1'b1;
        chunk_lpos = SCAN_LW'(k);
      end
    end
  end

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[CNT_W:1];
  assign mid_i   = mid[POS_W-1:0];
  assign mid_pad = {{POS_OUT_W{1'b0}}, mid};
  assign lin_pad = {{POS_OUT_W{1'b0}}, chunk_r, chunk_lpos};

  always_comb begin
    running_nxt = running_r;
    binary_nxt  = binary_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    chunk_nxt   = chunk_r;
    rsp         = '0;
    if (req.start) begin
      running_nxt = 1'b1;
      binary_nxt  = req.binary;
      lo_nxt      = '0;
      hi_nxt      = used;
      chunk_nxt   = '0;
    end else if (running_r) begin
      if (binary_r) begin
        if (lo_r >= hi_r) begin
          rsp.done = 1'b1;
        end else if (eq_vec[mid_i]) begin
          rsp.done = 1'b1;
          rsp.hit  = 1'b1;
          rsp.pos  = mid_pad[POS_OUT_W-1:0];
        end else if (lt_vec[mid_i]) begin
          lo_nxt = mid + CNT_W'(1);
        end else begin
          hi_nxt = mid;
        end
      end else begin
        if (chunk_any) begin
          rsp.done = 1'b1;
          rsp.hit  = 1'b1;
          rsp.pos  = lin_pad[POS_OUT_W-1:0];
        end else if (chunk_r == LAST_CHUNK) begin
          rsp.done = 1'b1;
        end else begin
          chunk_nxt = chunk_r + CH_W'(1);
        end
      end
      if (rsp.done) begin
        running_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
    end else begin
      running_r <= running_nxt;
    end
  end

  always_ff @(posedge clk) begin
    binary_r <= binary_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    chunk_r  <= chunk_nxt;
  end

endmodule

/* dv/tb_indexed_array_table_engine.sv */
// testbench for indexed_array_table_engine: random and directed requests against a shadow table
`timescale 1ns / 1ps

import iate_pkg::*;

typedef struct packed {
  logic [STATUS_W-1:0]  status;
  logic [POS_OUT_W-1:0] position;
  logic [COUNT_W-1:0]   entries;
} table_result_t;

class table_shadow;
  logic signed [VALUE_W-1:0] words [DEF_TABLE_DEPTH];
  int unsigned               used;
  logic [CAP_W-1:0]          capacity;
  table_result_t             pending_results [$];
  int                        errors;
  int                        results_seen;
  int                        n_full;
  int                        n_badidx;
  int                        n_hits;
  int                        n_misses;
  int                        peak_used;

  function new();
    used = 0;
    capacity = CAP_RESET;
    errors = 0;
    results_seen = 0;
    n_full = 0;
    n_badidx = 0;
    n_hits = 0;
    n_misses = 0;
    peak_used = 0;
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  // update the shadow table for one accepted request and queue its result word
  function void note_request(logic [OPCODE_W-1:0] op, logic signed [VALUE_W-1:0] value,
                             logic [INDEX_W-1:0] index);
    table_result_t r;
    int limit;
    int idx;
    int lo;
    int hi;
    int mid;
    int i;
    bit hit;
    r.status = ST_OK;
    r.position = '0;
    idx = int'(index);
    hit = 0;
    limit = int'(capacity);
    if (limit < 1) limit = 1;
    if (limit > DEF_TABLE_DEPTH) limit = DEF_TABLE_DEPTH;
    case (op)
      OP_INSERT: begin
        // full check wins over a bad index
        if (used >= limit) begin
          r.status = ST_FULL;
        end else if (idx > used) begin
          r.status = ST_BADIDX;
        end else begin
          for (i = used; i > idx; i--) words[i] = words[i-1];
          words[idx] = value;
          used++;
        end
      end
      OP_DELETE: begin
        if (idx >= used) begin
          r.status = ST_BADIDX;
        end else begin
          for (i = idx; i + 1 < used; i++) words[i] = words[i+1];
          used--;
        end
      end
      OP_BSRCH: begin
        // half-open range, first equal probe wins
        lo = 0;
        hi = used;
        while (lo < hi && !hit) begin
          mid = (lo + hi) / 2;
          if (words[mid] == value) begin
            hit = 1;
            r.position = POS_OUT_W'(mid);
          end else if (words[mid] < value) begin
            lo = mid + 1;
          end else begin
            hi = mid;
          end
        end
      end
      default: begin
        for (i = 0; i < used && !hit; i++) begin
          if (words[i] == value) begin
            hit = 1;
            r.position = POS_OUT_W'(i);
          end
        end
      end
    endcase
    if (op == OP_BSRCH || op == OP_LSRCH) begin
      if (hit) n_hits++;
      else begin
        r.status = ST_MISS;
        n_misses++;
      end
    end
    if (r.status == ST_FULL) n_full++;
    if (r.status == ST_BADIDX) n_badidx++;
    if (used > peak_used) peak_used = used;
    r.entries = COUNT_W'(used);
    pending_results.push_back(r);
  endfunction

  task report_mismatch(string what);
    errors++;
    // keep the log short on a badly broken block
    if (errors <= 100) $display("mismatch at result %0d: %s", results_seen, what);
  endtask

  task check_result(logic [STATUS_W-1:0] status, logic [POS_OUT_W-1:0] position,
                    logic [COUNT_W-1:0] entries);
    table_result_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result word with no request waiting (status %0d)", status));
    end else begin
      want = pending_results.pop_front();
      if (status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", status, want.status));
      if (position !== want.position)
        report_mismatch($sformatf("found_position %0d, want %0d", position, want.position));
      if (entries !== want.entries)
        report_mismatch($sformatf("entries_after %0d, want %0d", entries, want.entries));
    end
  endtask
endclass

module tb_indexed_array_table_engine;

  localparam int CYCLE_LIMIT = 300000;
  localparam int IDLE_SETTLE = 10;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 100;
  localparam logic [VALUE_W-1:0] MIN_WORD = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] MAX_WORD = 32'h7fff_ffff;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [OPCODE_W-1:0]  in_opcode;
  logic [VALUE_W-1:0]   in_item_value;
  logic [INDEX_W-1:0]   in_item_index;
  logic                 out_strobe;
  logic [STATUS_W-1:0]  out_status;
  logic [POS_OUT_W-1:0] out_found_position;
  logic [COUNT_W-1:0]   out_entries_after;
  logic                 cfg_wr_en;
  logic [CAP_W-1:0]     cfg_wr_data;

  table_shadow sb;
  int          cycle_count = 0;
  int          words_sent = 0;
  int          cap_writes = 0;

  // capacity, insert share and sorted-insert mode per random phase
  int phase_cap    [PHASES] = '{127, 127, 5, 1, 0, 64, 20, 2};
  int phase_ins    [PHASES] = '{60, 30, 50, 50, 50, 55, 40, 45};
  bit phase_sorted [PHASES] = '{1, 1, 1, 1, 0, 0, 0, 0};

  indexed_array_table_engine uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_opcode          (in_opcode),
    .in_item_value      (in_item_value),
    .in_item_index      (in_item_index),
    .out_strobe         (out_strobe),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_entries_after  (out_entries_after),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_strobe === 1'b1)
      sb.check_result(out_status, out_found_position, out_entries_after);
  end

  task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] value,
                           input logic [INDEX_W-1:0] index);
    @(negedge clk);
    start = 1'b1;
    in_opcode = op;
    in_item_value = value;
    in_item_index = index;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_request(op, value, index);
    words_sent++;
  endtask

  task automatic idle_gap();
    int roll;
    int n;
    roll = $urandom_range(0, 99);
    if (roll < 55) n = 0;
    else if (roll < 90) n = $urandom_range(1, 3);
    else n = $urandom_range(4, 40);
    if (n > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (IDLE_SETTLE) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(posedge clk);
    sb.capacity = value;
    cap_writes++;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    int sel;
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 16) - 8;
      1: begin
        sel = $urandom_range(0, 3);
        if (sel == 0) return MIN_WORD;
        else if (sel == 1) return MAX_WORD;
        else if (sel == 2) return '0;
        else return '1;
      end
      default: return $urandom();
    endcase
  endfunction

  // lower bound in ascending contents, keeps the table sorted
  function automatic int sorted_slot(logic signed [VALUE_W-1:0] value);
    int i;
    i = 0;
    while (i < sb.used && sb.words[i] < value) i++;
    return i;
  endfunction

  task automatic send_random(input int ins_pct, input bit keep_sorted);
    int                  roll;
    logic [OPCODE_W-1:0] op;
    logic [VALUE_W-1:0]  value;
    logic [INDEX_W-1:0]  index;
    roll = $urandom_range(0, 99);
    value = pick_value();
    index = INDEX_W'($urandom_range(0, 127));
    if (roll < ins_pct) begin
      op = OP_INSERT;
      if (keep_sorted) index = INDEX_W'(sorted_slot(value));
      else if ($urandom_range(0, 9) != 0) index = INDEX_W'($urandom_range(0, sb.used));
    end else if (roll < ins_pct + (100 - ins_pct) / 2) begin
      op = OP_DELETE;
      if (sb.used > 0 && $urandom_range(0, 9) != 0)
        index = INDEX_W'($urandom_range(0, sb.used - 1));
    end else begin
      op = ($urandom_range(0, 1) != 0) ? OP_BSRCH : OP_LSRCH;
      // mostly look for something that is stored
      if (sb.used > 0 && $urandom_range(0, 9) < 6)
        value = sb.words[$urandom_range(0, sb.used - 1)];
    end
    send_word(op, value, index);
  endtask

  initial begin
    int p;
    int k;
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = OP_INSERT;
    in_item_value = '0;
    in_item_index = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty table, bad indexes, extremes, default capacity
    send_word(OP_DELETE, '0, '0);
    send_word(OP_BSRCH, '0, '0);
    send_word(OP_LSRCH, MIN_WORD, '0);
    send_word(OP_INSERT, 32'd3, 7'd1);
    send_word(OP_INSERT, MIN_WORD, 7'd0);
    send_word(OP_INSERT, MAX_WORD, 7'd1);
    send_word(OP_INSERT, '0, 7'd1);
    send_word(OP_INSERT, 32'd5, '1);
    send_word(OP_BSRCH, MIN_WORD, '1);
    send_word(OP_BSRCH, MAX_WORD, '0);
    send_word(OP_BSRCH, '1, '0);
    send_word(OP_LSRCH, '0, '0);
    send_word(OP_DELETE, '0, 7'd3);
    send_word(OP_DELETE, '0, 7'd1);

    // full table wins over a bad index
    drain_results();
    write_capacity(7'd2);
    send_word(OP_INSERT, 32'd7, 7'd0);
    send_word(OP_INSERT, 32'd7, '1);

    // zero capacity acts as one, set below the current count
    drain_results();
    write_capacity(7'd0);
    send_word(OP_INSERT, 32'd9, 7'd0);
    send_word(OP_DELETE, '0, 7'd0);
    send_word(OP_INSERT, 32'd9, 7'd0);
    send_word(OP_DELETE, '0, 7'd0);
    send_word(OP_INSERT, '1, 7'd0);

    // capacity above depth, duplicates
    drain_results();
    write_capacity(7'd127);
    send_word(OP_INSERT, '1, 7'd1);
    send_word(OP_LSRCH, '1, '0);
    send_word(OP_BSRCH, '1, '0);

    for (p = 0; p < PHASES; p++) begin
      drain_results();
      write_capacity(CAP_W'(phase_cap[p]));
      for (k = 0; k < PHASE_ITEMS; k++) begin
        send_random(phase_ins[p], phase_sorted[p]);
        if ($urandom_range(0, 99) < 3) drain_results();
        else if (p % 3 != 2) idle_gap();
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    $display("sent %0d requests under %0d capacity settings, peak count %0d",
             words_sent, cap_writes, sb.peak_used);
    $display("search hits %0d, misses %0d, full %0d, bad index %0d, result mismatches %0d",
             sb.n_hits, sb.n_misses, sb.n_full, sb.n_badidx, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
